[src/rms_error_metric_unit_macros.svh]
// ----------------------------------------------------------------------------
// rms error metric unit assertion macros
// shared same-cycle and next-cycle implication checks on the unit clock
// ----------------------------------------------------------------------------
`ifndef RMS_ERROR_METRIC_UNIT_MACROS_SVH
`define RMS_ERROR_METRIC_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RMSEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmsem check failed");

// next-cycle implication, disabled in reset
`define RMSEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmsem check failed");

`endif

[src/rmsem_pkg.sv]
// ----------------------------------------------------------------------------
// rmsem_pkg
// shared constants, codes and state type of the rms error metric unit
// ----------------------------------------------------------------------------
`default_nettype none

package rmsem_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 2;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // register index of metric_mode
  localparam logic REG_MODE_IDX = 1'b0;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REL   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_REF = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_RR,
    BK_MUL_DEN,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

[src/rmsem_fifo.sv]
// ----------------------------------------------------------------------------
// rmsem_fifo
// two-entry word queue with occupancy count
// ----------------------------------------------------------------------------
`default_nettype none

module rmsem_fifo #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  output logic      [DATA_W-1:0] rd_data,
  output logic                   empty,
  output logic                   full,
  output logic      [1:0]        count
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[src/rmsem_front.sv]
// ----------------------------------------------------------------------------
// rmsem_front
// two-stage accumulator: squares and min/max, then running sums; emits a job
// ----------------------------------------------------------------------------
`default_nettype none

module rmsem_front #(
  parameter int SAMPLE_BITS = rmsem_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = rmsem_pkg::COUNT_BITS_DEF,
  localparam int SUM_W      = 2 * SAMPLE_BITS + COUNT_BITS,
  localparam int ENERGY_W   = 2 * SAMPLE_BITS + COUNT_BITS - 1,
  localparam int CNT_W      = COUNT_BITS + 1,
  localparam int JOB_W      = rmsem_pkg::MODE_W + 1 + CNT_W + SAMPLE_BITS + ENERGY_W + SUM_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic signed [SAMPLE_BITS-1:0] first_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] second_sample,
  input  wire logic                          last_item,
  input  wire logic [rmsem_pkg::MODE_W-1:0]  metric_mode,
  output logic                               pend_last,
  output logic                               job_push,
  output logic [JOB_W-1:0]                   job_data
);

  localparam logic signed [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // set state
  logic signed [SAMPLE_BITS-1:0] smallest_second;
  logic signed [SAMPLE_BITS-1:0] largest_second;
  logic [CNT_W-1:0]              pair_count;
  logic                          count_overflowed;
  logic [SUM_W-1:0]              difference_sum;
  logic [ENERGY_W-1:0]           reference_energy;

  // stage registers
  logic                          p_valid;
  logic                          p_take;
  logic                          p_last;
  logic [2*SAMPLE_BITS-1:0]      p_sqd;
  logic [2*SAMPLE_BITS-1:0]      p_sqa;
  logic [SAMPLE_BITS-1:0]        p_range;
  logic [CNT_W-1:0]              p_count;
  logic                          p_ovf;
  logic [rmsem_pkg::MODE_W-1:0]  p_mode;

  logic                          take;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        abs_d;
  logic [SAMPLE_BITS-1:0]        abs_a;
  logic signed [SAMPLE_BITS-1:0] smallest_next;
  logic signed [SAMPLE_BITS-1:0] largest_next;
  logic signed [SAMPLE_BITS:0]   range_wide;
  logic [CNT_W-1:0]              pair_count_next;
  logic                          count_overflowed_next;
  logic [SUM_W-1:0]              difference_sum_next;
  logic [ENERGY_W-1:0]           reference_energy_next;

  always_comb begin
    take  = !pair_count[CNT_W-1];
    diff  = (SAMPLE_BITS+1)'(first_sample) - (SAMPLE_BITS+1)'(second_sample);
    abs_d = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
    abs_a = first_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-first_sample) : first_sample;
    smallest_next = (take && second_sample < smallest_second) ? second_sample
                                                              : smallest_second;
    largest_next  = (take && second_sample > largest_second) ? second_sample
                                                             : largest_second;
    range_wide    = (SAMPLE_BITS+1)'(largest_next) - (SAMPLE_BITS+1)'(smallest_next);
    pair_count_next       = take ? pair_count + CNT_W'(1) : pair_count;
    count_overflowed_next = count_overflowed | !take;
    difference_sum_next   = p_take ? difference_sum + SUM_W'(p_sqd) : difference_sum;
    reference_energy_next = p_take ? reference_energy + ENERGY_W'(p_sqa)
                                   : reference_energy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smallest_second  <= MAX_POS;
      largest_second   <= MIN_NEG;
      pair_count       <= '0;
      count_overflowed <= 1'b0;
      difference_sum   <= '0;
      reference_energy <= '0;
      p_valid          <= 1'b0;
    end else begin
      p_valid <= accept;
      if (accept) begin
        if (last_item) begin
          smallest_second  <= MAX_POS;
          largest_second   <= MIN_NEG;
          pair_count       <= '0;
          count_overflowed <= 1'b0;
        end else begin
          smallest_second  <= smallest_next;
          largest_second   <= largest_next;
          pair_count       <= pair_count_next;
          count_overflowed <= count_overflowed_next;
        end
      end
      if (p_valid) begin
        if (p_last) begin
          difference_sum   <= '0;
          reference_energy <= '0;
        end else begin
          difference_sum   <= difference_sum_next;
          reference_energy <= reference_energy_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_take  <= take;
      p_last  <= last_item;
      p_sqd   <= abs_d * abs_d;
      p_sqa   <= abs_a * abs_a;
      p_range <= range_wide[SAMPLE_BITS-1:0];
      p_count <= pair_count_next;
      p_ovf   <= count_overflowed_next;
      p_mode  <= metric_mode;
    end
  end

  assign pend_last = p_valid && p_last;
  assign job_push  = p_valid && p_last;
  assign job_data  = {p_mode, p_ovf, p_count, p_range,
                      reference_energy_next, difference_sum_next};

endmodule

`default_nettype wire

[src/rmsem_back.sv]
// ----------------------------------------------------------------------------
// rmsem_back
// per-set finisher: denominator, restoring divide, digit-by-digit root
// ----------------------------------------------------------------------------
`default_nettype none

module rmsem_back #(
  parameter int SAMPLE_BITS   = rmsem_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS    = rmsem_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = rmsem_pkg::FRACTION_BITS_DEF,
  localparam int SUM_W    = 2 * SAMPLE_BITS + COUNT_BITS,
  localparam int ENERGY_W = 2 * SAMPLE_BITS + COUNT_BITS - 1,
  localparam int CNT_W    = COUNT_BITS + 1,
  localparam int JOB_W    = rmsem_pkg::MODE_W + 1 + CNT_W + SAMPLE_BITS + ENERGY_W + SUM_W,
  localparam int RES_W    = rmsem_pkg::STATUS_W + rmsem_pkg::VALUE_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [JOB_W-1:0] job_data,
  input  wire logic             job_empty,
  output logic                  job_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output logic [RES_W-1:0]      res_data
);

  localparam int DEN_W  = SUM_W;
  localparam int NUM_W  = SUM_W + 2 * FRACTION_BITS;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int OP_W   = 2 * ROOT_W;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int RX_W   = (ROOT_W > rmsem_pkg::VALUE_W) ? ROOT_W : rmsem_pkg::VALUE_W + 1;

  rmsem_pkg::back_state_t state, state_next;

  logic [rmsem_pkg::MODE_W-1:0] j_mode;
  logic                         j_ovf;
  logic [CNT_W-1:0]             j_count;
  logic [SAMPLE_BITS-1:0]       j_range;
  logic [ENERGY_W-1:0]          j_energy;
  logic [SUM_W-1:0]             j_sum;

  assign {j_mode, j_ovf, j_count, j_range, j_energy, j_sum} = job_data;

  logic [CNT_W-1:0]              count;
  logic [SAMPLE_BITS-1:0]        range;
  logic [2*SAMPLE_BITS-1:0]      range_sq;
  logic [DEN_W-1:0]              den;
  logic [NUM_W-1:0]              num;
  logic [DEN_W-1:0]              rem_d;
  logic [OP_W-1:0]               op;
  logic [ROOT_W+1:0]             rem_s;
  logic [ROOT_W-1:0]             root;
  logic [STEP_W-1:0]             step;
  logic [rmsem_pkg::VALUE_W-1:0] value;
  logic [rmsem_pkg::STATUS_W-1:0] status;

  logic                 div_last;
  logic                 sqrt_last;
  logic [DEN_W:0]       rd_sh;
  logic                 rd_ge;
  logic [DEN_W:0]       rd_diff;
  logic [DEN_W-1:0]     rem_d_next;
  logic [NUM_W-1:0]     num_next;
  logic [ROOT_W+1:0]    rs_sh;
  logic [ROOT_W+1:0]    trial;
  logic                 rs_ge;
  logic [ROOT_W+1:0]    rem_s_next;
  logic [ROOT_W-1:0]    root_next;
  logic [RX_W-1:0]      root_x;
  logic [rmsem_pkg::VALUE_W-1:0] value_sat;

  always_comb begin
    div_last   = (step == STEP_W'(NUM_W - 1));
    sqrt_last  = (step == STEP_W'(ROOT_W - 1));
    rd_sh      = {rem_d, num[NUM_W-1]};
    rd_ge      = (rd_sh >= {1'b0, den});
    rd_diff    = rd_sh - {1'b0, den};
    rem_d_next = rd_ge ? rd_diff[DEN_W-1:0] : rd_sh[DEN_W-1:0];
    num_next   = {num[NUM_W-2:0], rd_ge};
    rs_sh      = {rem_s[ROOT_W-1:0], op[OP_W-1 -: 2]};
    trial      = {root, 2'b01};
    rs_ge      = (rs_sh >= trial);
    rem_s_next = rs_ge ? rs_sh - trial : rs_sh;
    root_next  = {root[ROOT_W-2:0], rs_ge};
    root_x     = RX_W'(root_next);
    // anything above 32 integer-plus-fraction bits saturates
    value_sat  = (|root_x[RX_W-1:rmsem_pkg::VALUE_W]) ? '1
                                                      : root_x[rmsem_pkg::VALUE_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rmsem_pkg::BK_IDLE: begin
        if (!job_empty) begin
          if (j_ovf) begin
            state_next = rmsem_pkg::BK_DONE;
          end else if (j_mode == rmsem_pkg::MODE_NORM) begin
            state_next = (j_range == '0) ? rmsem_pkg::BK_DONE : rmsem_pkg::BK_MUL_RR;
          end else if (j_mode == rmsem_pkg::MODE_REL) begin
            state_next = (j_energy == '0) ? rmsem_pkg::BK_DONE : rmsem_pkg::BK_DIV;
          end else begin
            state_next = rmsem_pkg::BK_DIV;
          end
        end
      end
      rmsem_pkg::BK_MUL_RR:  state_next = rmsem_pkg::BK_MUL_DEN;
      rmsem_pkg::BK_MUL_DEN: state_next = rmsem_pkg::BK_DIV;
      rmsem_pkg::BK_DIV: begin
        if (div_last) begin
          state_next = rmsem_pkg::BK_SQRT;
        end
      end
      rmsem_pkg::BK_SQRT: begin
        if (sqrt_last) begin
          state_next = rmsem_pkg::BK_DONE;
        end
      end
      rmsem_pkg::BK_DONE: begin
        if (!res_full) begin
          state_next = rmsem_pkg::BK_IDLE;
        end
      end
      default: state_next = rmsem_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop  = 1'b0;
    res_push = 1'b0;
    case (state)
      rmsem_pkg::BK_IDLE: job_pop  = !job_empty;
      rmsem_pkg::BK_DONE: res_push = !res_full;
      default: begin
        job_pop  = 1'b0;
        res_push = 1'b0;
      end
    endcase
  end

  assign res_data = {status, value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsem_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rmsem_pkg::BK_IDLE: begin
        count <= j_count;
        range <= j_range;
        num   <= {j_sum, {(2*FRACTION_BITS){1'b0}}};
        rem_d <= '0;
        rem_s <= '0;
        root  <= '0;
        step  <= '0;
        value <= '0;
        den   <= (j_mode == rmsem_pkg::MODE_REL) ? DEN_W'(j_energy) : DEN_W'(j_count);
        if (j_ovf) begin
          status <= rmsem_pkg::STATUS_OVERFLOW;
        end else if (j_mode == rmsem_pkg::MODE_REL && j_energy == '0) begin
          status <= rmsem_pkg::STATUS_ZERO_REF;
        end else begin
          status <= rmsem_pkg::STATUS_OK;
        end
      end
      rmsem_pkg::BK_MUL_RR: begin
        range_sq <= range * range;
      end
      rmsem_pkg::BK_MUL_DEN: begin
        den <= DEN_W'(count * range_sq);
      end
      rmsem_pkg::BK_DIV: begin
        rem_d <= rem_d_next;
        num   <= num_next;
        step  <= div_last ? '0 : step + STEP_W'(1);
        if (div_last) begin
          op <= OP_W'(num_next);
        end
      end
      rmsem_pkg::BK_SQRT: begin
        rem_s <= rem_s_next;
        root  <= root_next;
        op    <= op << 2;
        step  <= step + STEP_W'(1);
        if (sqrt_last) begin
          value <= value_sat;
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/rms_error_metric_unit.sv]
// rms error metric unit: one sample pair accepted per cycle while the set queue has room
// a set's word passes the accumulator stage, the set queue and the back end, which runs
//   the range-square and denominator multiply states first in normalized mode, then a
//   restoring divide of NUM_W = 2*SAMPLE_BITS + COUNT_BITS + 2*FRACTION_BITS bits (80 at
//   defaults) and a root of ROOT_W = NUM_W/2 rounded up (40) bits; it finishes one set
//   before the next; reset: synchronous rst clears control state and sums, not data regs at all
// ----------------------------------------------------------------------------
// rms_error_metric_unit
// root-mean-square error over sets of signed sample pairs, Q16.16 result
// ----------------------------------------------------------------------------
`default_nettype none
`include "rms_error_metric_unit_macros.svh"

module rms_error_metric_unit #(
  parameter int SAMPLE_BITS   = rmsem_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS    = rmsem_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = rmsem_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // sample pair input queue side
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic signed [SAMPLE_BITS-1:0]   first_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]   second_sample,
  input  wire logic                            last_item,
  // result queue side
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [rmsem_pkg::VALUE_W-1:0]        error_value,
  output logic [rmsem_pkg::STATUS_W-1:0]       status_code,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rmsem_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rmsem_pkg::APB_DW-1:0]    pwdata,
  output logic [rmsem_pkg::APB_DW-1:0]         prdata,
  output logic                                 pready
);

  localparam int SUM_W    = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int ENERGY_W = 2 * SAMPLE_BITS + COUNT_BITS - 1;
  localparam int CNT_W    = COUNT_BITS + 1;
  localparam int JOB_W    = rmsem_pkg::MODE_W + 1 + CNT_W + SAMPLE_BITS + ENERGY_W + SUM_W;
  localparam int RES_W    = rmsem_pkg::STATUS_W + rmsem_pkg::VALUE_W;

  // configuration register, only metric_mode at index 0
  logic [rmsem_pkg::MODE_W-1:0] metric_mode;
  logic                         cfg_wr;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == rmsem_pkg::REG_MODE_IDX);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? rmsem_pkg::APB_DW'(metric_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= rmsem_pkg::MODE_PLAIN;
    end else if (cfg_wr) begin
      metric_mode <= pwdata[rmsem_pkg::MODE_W-1:0];
    end
  end

  // front end: accumulator, runs one pair per cycle while the set queue has room
  logic             accept;
  logic             pend_last;
  logic             job_push;
  logic [JOB_W-1:0] job_wdata;

  // set queue between front and back
  logic [JOB_W-1:0] job_rdata;
  logic             job_empty;
  logic             job_full;
  logic [1:0]       job_count;
  logic             job_pop;

  // a last pair still in the accumulator stage holds a queue slot in advance
  assign full   = (3'(job_count) + 3'(pend_last)) >= 3'd2;
  assign accept = push && !full;

  rmsem_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .first_sample  (first_sample),
    .second_sample (second_sample),
    .last_item     (last_item),
    .metric_mode   (metric_mode),
    .pend_last     (pend_last),
    .job_push      (job_push),
    .job_data      (job_wdata)
  );

  rmsem_fifo #(
    .DATA_W (JOB_W)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .rd_en   (job_pop),
    .rd_data (job_rdata),
    .empty   (job_empty),
    .full    (job_full),
    .count   (job_count)
  );

  // back end: denominator, divide and root for each finished set
  logic             res_push;
  logic [RES_W-1:0] res_wdata;
  logic [RES_W-1:0] res_rdata;
  logic             res_full;
  logic [1:0]       res_count;

  rmsem_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_data  (job_rdata),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  // result queue, lets the back end start the next set while a word waits
  rmsem_fifo #(
    .DATA_W (RES_W)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wdata),
    .rd_en   (pop),
    .rd_data (res_rdata),
    .empty   (empty),
    .full    (res_full),
    .count   (res_count)
  );

  assign {status_code, error_value} = res_rdata;

  // checks
  `RMSEM_ASSERT_NOW(a_job_room, job_push, !job_full)
  `RMSEM_ASSERT_NOW(a_res_room, res_push, !res_full)
  `RMSEM_ASSERT_NOW(a_err_zero, !empty && status_code != rmsem_pkg::STATUS_OK,
    error_value == '0)
  `RMSEM_ASSERT_NOW(a_status_code, !empty,
    status_code <= rmsem_pkg::STATUS_OVERFLOW && res_count <= 2'd2)

endmodule

`default_nettype wire
